// ----- design/blg_pkg.sv -----
// ----------------------------------------------------------------------------
// blg_pkg: shared types and constants of the battery level gauge
// Widths, register map codes, sequencer states and shared-adder request types.
// ----------------------------------------------------------------------------
`default_nettype none

package blg_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int FRACTION_BITS = 8;
  localparam int STATE_BITS    = SAMPLE_BITS + FRACTION_BITS;
  localparam int WEIGHT_BITS   = 9;
  localparam int WEIGHT_SHIFT  = 8;
  localparam int PCT_BITS      = 7;
  localparam int ALU_BITS      = STATE_BITS + WEIGHT_BITS;
  localparam int CNT_BITS      = 4;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(256);
  localparam logic [ALU_BITS-1:0]    ROUND_ADD  = ALU_BITS'(255);
  localparam logic [PCT_BITS-1:0]    PCT_FULL   = PCT_BITS'(100);
  localparam logic [CNT_BITS-1:0]    MUL_LAST   = CNT_BITS'(WEIGHT_BITS - 1);
  localparam logic [CNT_BITS-1:0]    DIV_LAST   = CNT_BITS'(PCT_BITS - 1);

  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;
  localparam int IN_DATA_BITS  = 16;
  localparam int OUT_DATA_BITS = 24;

  localparam logic [1:0] REG_FULL   = 2'd0;
  localparam logic [1:0] REG_EMPTY  = 2'd1;
  localparam logic [1:0] REG_WEIGHT = 2'd2;

  localparam logic [SAMPLE_BITS-1:0] FULL_RST   = SAMPLE_BITS'(3474);
  localparam logic [SAMPLE_BITS-1:0] EMPTY_RST  = SAMPLE_BITS'(2643);
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RST = WEIGHT_BITS'(26);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_DIFF  = 14'b00000000000010,
    ST_NDIFF = 14'b00000000000100,
    ST_MUL   = 14'b00000000001000,
    ST_RND   = 14'b00000000010000,
    ST_UPD   = 14'b00000000100000,
    ST_FULL  = 14'b00000001000000,
    ST_EMPTY = 14'b00000010000000,
    ST_SPAN  = 14'b00000100000000,
    ST_NUM   = 14'b00001000000000,
    ST_M1    = 14'b00010000000000,
    ST_M2    = 14'b00100000000000,
    ST_DIV   = 14'b01000000000000,
    ST_DONE  = 14'b10000000000000
  } blg_state_t;

  typedef struct packed {
    logic                sub;
    logic [ALU_BITS-1:0] a;
    logic [ALU_BITS-1:0] b;
  } blg_alu_req_t;

  typedef struct packed {
    logic                carry;
    logic [ALU_BITS-1:0] sum;
  } blg_alu_res_t;

endpackage

`default_nettype wire

// ----- design/blg_alu.sv -----
// ----------------------------------------------------------------------------
// blg_alu: shared adder/subtractor
// One wide add or subtract per cycle; carry set on subtract means a >= b.
// ----------------------------------------------------------------------------
`default_nettype none

module blg_alu (
  input  blg_pkg::blg_alu_req_t req,
  output blg_pkg::blg_alu_res_t res
);

  logic [blg_pkg::ALU_BITS:0] total;

  assign total = {1'b0, req.a}
               + {1'b0, (req.sub ? ~req.b : req.b)}
               + {{blg_pkg::ALU_BITS{1'b0}}, req.sub};

  assign res.carry = total[blg_pkg::ALU_BITS];
  assign res.sum   = total[blg_pkg::ALU_BITS-1:0];

endmodule

`default_nettype wire

// ----- design/blg_engine.sv -----
// ----------------------------------------------------------------------------
// blg_engine: filter and percentage sequencer
// Shift-add filter update and restoring division, all on one shared adder.
// ----------------------------------------------------------------------------
`default_nettype none

module blg_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [blg_pkg::SAMPLE_BITS-1:0]     sample,
  input  logic                                conv_ok,
  input  logic [blg_pkg::SAMPLE_BITS-1:0]     full_level,
  input  logic [blg_pkg::SAMPLE_BITS-1:0]     empty_level,
  input  logic [blg_pkg::WEIGHT_BITS-1:0]     filter_weight,
  input  logic                                res_ready,
  output logic                                idle,
  output logic                                done,
  output logic [blg_pkg::PCT_BITS-1:0]        percent,
  output logic [blg_pkg::SAMPLE_BITS-1:0]     filtered_level
);

  localparam int AB = blg_pkg::ALU_BITS;
  localparam int SB = blg_pkg::STATE_BITS;
  localparam int FB = blg_pkg::FRACTION_BITS;

  blg_pkg::blg_state_t              state_r, state_nxt;
  logic [SB-1:0]                    f_r, f_nxt;
  logic [SB-1:0]                    s_r, s_nxt;
  logic [blg_pkg::WEIGHT_BITS-1:0]  w_r, w_nxt;
  logic [AB-1:0]                    acc_r, acc_nxt;
  logic [AB-1:0]                    md_r, md_nxt;
  logic                             neg_r, neg_nxt;
  logic [blg_pkg::CNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic [blg_pkg::PCT_BITS-1:0]     pct_r, pct_nxt;
  logic [blg_pkg::SAMPLE_BITS-1:0]  span_r, span_nxt;

  blg_pkg::blg_alu_req_t            req;
  blg_pkg::blg_alu_res_t            res;

  blg_alu u_alu (
    .req (req),
    .res (res)
  );

  always_comb begin
    state_nxt = state_r;
    f_nxt     = f_r;
    s_nxt     = s_r;
    w_nxt     = w_r;
    acc_nxt   = acc_r;
    md_nxt    = md_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    pct_nxt   = pct_r;
    span_nxt  = span_r;
    req.sub   = 1'b0;
    req.a     = '0;
    req.b     = '0;
    case (state_r)
      blg_pkg::ST_IDLE: begin
        if (start) begin
          s_nxt = {sample, {FB{1'b0}}};
          w_nxt = (filter_weight > blg_pkg::WEIGHT_ONE) ? blg_pkg::WEIGHT_ONE : filter_weight;
          if (!conv_ok) begin
            pct_nxt   = '0;
            state_nxt = blg_pkg::ST_DONE;
          end else if (f_r == '0) begin
            f_nxt     = {sample, {FB{1'b0}}};
            state_nxt = blg_pkg::ST_FULL;
          end else begin
            state_nxt = blg_pkg::ST_DIFF;
          end
        end
      end
      blg_pkg::ST_DIFF: begin
        req.sub = 1'b1;
        req.a   = AB'(s_r);
        req.b   = AB'(f_r);
        acc_nxt = '0;
        cnt_nxt = '0;
        md_nxt  = AB'(res.sum[SB-1:0]);
        neg_nxt = !res.carry;
        state_nxt = res.carry ? blg_pkg::ST_MUL : blg_pkg::ST_NDIFF;
      end
      blg_pkg::ST_NDIFF: begin
        req.sub   = 1'b1;
        req.a     = AB'(f_r);
        req.b     = AB'(s_r);
        md_nxt    = AB'(res.sum[SB-1:0]);
        state_nxt = blg_pkg::ST_MUL;
      end
      blg_pkg::ST_MUL: begin
        req.a   = acc_r;
        req.b   = w_r[0] ? md_r : '0;
        acc_nxt = res.sum;
        md_nxt  = md_r << 1;
        w_nxt   = w_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == blg_pkg::MUL_LAST) begin
          state_nxt = neg_r ? blg_pkg::ST_RND : blg_pkg::ST_UPD;
        end
      end
      blg_pkg::ST_RND: begin
        req.a     = acc_r;
        req.b     = blg_pkg::ROUND_ADD;
        acc_nxt   = res.sum;
        state_nxt = blg_pkg::ST_UPD;
      end
      blg_pkg::ST_UPD: begin
        req.sub   = neg_r;
        req.a     = AB'(f_r);
        req.b     = acc_r >> blg_pkg::WEIGHT_SHIFT;
        f_nxt     = res.sum[SB-1:0];
        state_nxt = blg_pkg::ST_FULL;
      end
      blg_pkg::ST_FULL: begin
        req.sub = 1'b1;
        req.a   = AB'(f_r);
        req.b   = AB'({full_level, {FB{1'b0}}});
        if (res.carry) begin
          pct_nxt   = blg_pkg::PCT_FULL;
          state_nxt = blg_pkg::ST_DONE;
        end else begin
          state_nxt = blg_pkg::ST_EMPTY;
        end
      end
      blg_pkg::ST_EMPTY: begin
        req.sub = 1'b1;
        req.a   = AB'({empty_level, {FB{1'b0}}});
        req.b   = AB'(f_r);
        if (res.carry) begin
          pct_nxt   = '0;
          state_nxt = blg_pkg::ST_DONE;
        end else begin
          state_nxt = blg_pkg::ST_SPAN;
        end
      end
      blg_pkg::ST_SPAN: begin
        req.sub   = 1'b1;
        req.a     = AB'(full_level);
        req.b     = AB'(empty_level);
        span_nxt  = res.sum[blg_pkg::SAMPLE_BITS-1:0];
        state_nxt = blg_pkg::ST_NUM;
      end
      blg_pkg::ST_NUM: begin
        req.sub   = 1'b1;
        req.a     = AB'(f_r[SB-1:FB]);
        req.b     = AB'(empty_level);
        md_nxt    = AB'(res.sum[blg_pkg::SAMPLE_BITS-1:0]);
        state_nxt = blg_pkg::ST_M1;
      end
      blg_pkg::ST_M1: begin
        req.a     = md_r << 6;
        req.b     = md_r << 5;
        acc_nxt   = res.sum;
        state_nxt = blg_pkg::ST_M2;
      end
      blg_pkg::ST_M2: begin
        req.a     = acc_r;
        req.b     = md_r << 2;
        acc_nxt   = res.sum;
        md_nxt    = AB'(span_r) << (blg_pkg::PCT_BITS - 1);
        cnt_nxt   = '0;
        pct_nxt   = '0;
        state_nxt = blg_pkg::ST_DIV;
      end
      blg_pkg::ST_DIV: begin
        req.sub = 1'b1;
        req.a   = acc_r;
        req.b   = md_r;
        if (res.carry) begin
          acc_nxt = res.sum;
        end
        pct_nxt = {pct_r[blg_pkg::PCT_BITS-2:0], res.carry};
        md_nxt  = md_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == blg_pkg::DIV_LAST) begin
          state_nxt = blg_pkg::ST_DONE;
        end
      end
      blg_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = blg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = blg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= blg_pkg::ST_IDLE;
      f_r     <= '0;
    end else begin
      state_r <= state_nxt;
      f_r     <= f_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    w_r    <= w_nxt;
    acc_r  <= acc_nxt;
    md_r   <= md_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    pct_r  <= pct_nxt;
    span_r <= span_nxt;
  end

  assign idle           = (state_r == blg_pkg::ST_IDLE);
  assign done           = (state_r == blg_pkg::ST_DONE) && res_ready;
  assign percent        = pct_r;
  assign filtered_level = f_r[SB-1:FB];

endmodule

`default_nettype wire

// ----- design/battery_level_gauge_core.sv -----
// ----------------------------------------------------------------------------
// battery_level_gauge_core: smoothed battery charge percentage
// Stream in raw samples, stream out percent and filtered level; APB registers.
// ----------------------------------------------------------------------------
// Each request carries a 12-bit converter sample and a conversion-ok flag and
// yields one result: charge percent (0..100) and the integer part of the
// low-pass filter state. A failed conversion yields percent 0 and a priming
// load skips the multiply; a full update runs the 9-step shift-add weight
// multiply and the 7-step restoring divide, both running on one shared
// adder. The block takes a new request as soon as the sequencer is
// back in idle, even while the previous result waits in the output register.
// Write registers only while no request is in flight.
`default_nettype none

module battery_level_gauge_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [blg_pkg::IN_DATA_BITS-1:0]     in_tdata,   // [11:0] sample
  input  logic                                 in_tuser,   // [0] conversion_ok
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [blg_pkg::OUT_DATA_BITS-1:0]    out_tdata,  // [6:0] percent, [18:7] filtered_level
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [blg_pkg::CFG_ADDR_BITS-1:0]    cfg_paddr,
  input  logic [blg_pkg::CFG_DATA_BITS-1:0]    cfg_pwdata,
  output logic [blg_pkg::CFG_DATA_BITS-1:0]    cfg_prdata,
  output logic                                 cfg_pready
);

  logic [blg_pkg::SAMPLE_BITS-1:0] full_r, full_nxt;
  logic [blg_pkg::SAMPLE_BITS-1:0] empty_r, empty_nxt;
  logic [blg_pkg::WEIGHT_BITS-1:0] weight_r, weight_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [blg_pkg::PCT_BITS-1:0]    out_pct_r, out_pct_nxt;
  logic [blg_pkg::SAMPLE_BITS-1:0] out_lvl_r, out_lvl_nxt;

  logic                            cfg_wr;
  logic [1:0]                      cfg_idx;
  logic                            eng_idle;
  logic                            eng_done;
  logic                            res_ready;
  logic [blg_pkg::PCT_BITS-1:0]    eng_pct;
  logic [blg_pkg::SAMPLE_BITS-1:0] eng_lvl;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    full_nxt   = full_r;
    empty_nxt  = empty_r;
    weight_nxt = weight_r;
    if (cfg_wr) begin
      case (cfg_idx)
        blg_pkg::REG_FULL:   full_nxt   = cfg_pwdata[blg_pkg::SAMPLE_BITS-1:0];
        blg_pkg::REG_EMPTY:  empty_nxt  = cfg_pwdata[blg_pkg::SAMPLE_BITS-1:0];
        blg_pkg::REG_WEIGHT: weight_nxt = cfg_pwdata[blg_pkg::WEIGHT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      blg_pkg::REG_FULL:   cfg_prdata = blg_pkg::CFG_DATA_BITS'(full_r);
      blg_pkg::REG_EMPTY:  cfg_prdata = blg_pkg::CFG_DATA_BITS'(empty_r);
      blg_pkg::REG_WEIGHT: cfg_prdata = blg_pkg::CFG_DATA_BITS'(weight_r);
      default:             cfg_prdata = '0;
    endcase
  end

  assign in_tready = eng_idle;
  assign res_ready = !out_valid_r || out_tready;

  blg_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (in_tvalid && in_tready),
    .sample         (in_tdata[blg_pkg::SAMPLE_BITS-1:0]),
    .conv_ok        (in_tuser),
    .full_level     (full_r),
    .empty_level    (empty_r),
    .filter_weight  (weight_r),
    .res_ready      (res_ready),
    .idle           (eng_idle),
    .done           (eng_done),
    .percent        (eng_pct),
    .filtered_level (eng_lvl)
  );

  // hold the result until taken; load a new one as the slot frees
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pct_nxt   = out_pct_r;
    out_lvl_nxt   = out_lvl_r;
    if (eng_done) begin
      out_valid_nxt = 1'b1;
      out_pct_nxt   = eng_pct;
      out_lvl_nxt   = eng_lvl;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r      <= blg_pkg::FULL_RST;
      empty_r     <= blg_pkg::EMPTY_RST;
      weight_r    <= blg_pkg::WEIGHT_RST;
      out_valid_r <= 1'b0;
    end else begin
      full_r      <= full_nxt;
      empty_r     <= empty_nxt;
      weight_r    <= weight_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pct_r <= out_pct_nxt;
    out_lvl_r <= out_lvl_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = blg_pkg::OUT_DATA_BITS'({out_lvl_r, out_pct_r});

endmodule

`default_nettype wire
